// ===== rtl/pats_pkg.sv =====
// pats_pkg: shared types and constants of the priority aging task scheduler
// no dependencies; imported by every other file of the block

package pats_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TASK_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int PRIO_W    = 6;
  localparam int OP_W      = 2;
  localparam int TIME_W    = 32;
  localparam int QUANT_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  localparam logic signed [PRIO_W-1:0] PRIO_FLOOR = -6'sd20;
  localparam logic signed [PRIO_W-1:0] PRIO_CEIL  = 6'sd20;
  localparam logic signed [PRIO_W-1:0] PRIO_ONE   = 6'sd1;
  localparam logic signed [PRIO_W-1:0] PRIO_TOP   = 6'sd31;

  localparam logic [QUANT_W-1:0] QUANTUM_RST = 8'd20;
  localparam logic [TASK_W-1:0]  NONPRE_RST  = 4'd1;

  typedef enum logic [OP_W-1:0] {
    OP_SET_PRIO   = 2'd0,
    OP_MAKE_READY = 2'd1,
    OP_DISPATCH   = 2'd2,
    OP_TICK       = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM = 1'b0,
    CFG_NONPRE  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic disp_init;
    logic scan;
    logic pick;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic expire;
    logic count_zero;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/pats_if.sv =====
// pats_if: input, result and configuration channel interfaces
// depends on pats_pkg for payload widths

interface pats_in_if import pats_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [TASK_W-1:0]        task_number;
  logic signed [PRIO_W-1:0] priority_req;

  modport source (output valid, output operation, output task_number,
                  output priority_req, input ready);
  modport sink (input valid, input operation, input task_number,
                input priority_req, output ready);
  modport monitor (input valid, input ready, input operation, input task_number,
                   input priority_req);
endinterface

interface pats_out_if import pats_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              chosen_valid;
  logic [TASK_W-1:0] chosen_task;
  logic              queue_empty;
  logic [TIME_W-1:0] system_time;

  modport source (output valid, output chosen_valid, output chosen_task,
                  output queue_empty, output system_time, input ready);
  modport sink (input valid, input chosen_valid, input chosen_task,
                input queue_empty, input system_time, output ready);
  modport monitor (input valid, input ready, input chosen_valid, input chosen_task,
                   input queue_empty, input system_time);
endinterface

interface pats_cfg_if import pats_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
  modport monitor (input valid, input ready, input index, input data);
endinterface

// ===== rtl/pats_ctrl.sv =====
// pats_ctrl: sequencer of the scheduler, one item at a time
// depends on pats_pkg for command and status types

module pats_ctrl import pats_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_DISP = 6'b000100,
    S_SCAN = 6'b001000,
    S_PICK = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.op == OP_DISPATCH || (status_i.op == OP_TICK && status_i.expire)) begin
          state_d = S_DISP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DISP: begin
        if (status_i.count_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.disp_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/pats_dpath.sv =====
// pats_dpath: task table, ready queue, timers and result register
// depends on pats_pkg; driven by pats_ctrl commands

module pats_dpath import pats_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  logic [OP_W-1:0]          operation_i,
  input  logic [TASK_W-1:0]        task_number_i,
  input  logic signed [PRIO_W-1:0] priority_req_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DAT_W-1:0]     cfg_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     chosen_valid_o,
  output logic [TASK_W-1:0]        chosen_task_o,
  output logic                     queue_empty_o,
  output logic [TIME_W-1:0]        system_time_o
);

  op_e                      op_q;
  logic [TASK_W-1:0]        tn_q;
  logic signed [PRIO_W-1:0] prio_q;

  logic signed [PRIO_W-1:0] sp_q [MAX_TASKS];
  logic signed [PRIO_W-1:0] dp_q [MAX_TASKS];
  logic [TASK_W-1:0]        ro_q [MAX_TASKS];
  logic [CNT_W-1:0]         cnt_q;
  logic [TASK_W-1:0]        cur_q;
  logic [QUANT_W-1:0]       ql_q;
  logic [TIME_W-1:0]        tick_q;
  logic [QUANT_W-1:0]       qt_q;
  logic [TASK_W-1:0]        np_q;

  logic [CNT_W-1:0]         k_q;
  logic [TASK_W-1:0]        best_q;
  logic signed [PRIO_W-1:0] bestp_q;
  logic                     pv_q;
  logic [TASK_W-1:0]        pt_q;

  logic                     out_valid_q;
  logic                     chosen_valid_q;
  logic [TASK_W-1:0]        chosen_task_q;
  logic                     queue_empty_q;
  logic [TIME_W-1:0]        system_time_q;

  logic signed [PRIO_W-1:0] prio_sat;
  logic [TASK_W-1:0]        app_task;
  logic                     dup;
  logic                     app_ok;
  logic                     do_append;
  logic [QUANT_W-1:0]       ql_dec;
  logic                     preempt;
  logic                     expire;
  logic [TASK_W-1:0]        scan_j;
  logic [TASK_W-1:0]        scan_e;
  logic signed [PRIO_W-1:0] scan_v;
  logic signed [PRIO_W-1:0] scan_aged;
  logic                     scan_better;
  logic [TASK_W-1:0]        pick_t;
  logic                     out_free;

  always_comb begin
    if (prio_q < PRIO_FLOOR) begin
      prio_sat = PRIO_FLOOR;
    end else if (prio_q > PRIO_CEIL) begin
      prio_sat = PRIO_CEIL;
    end else begin
      prio_sat = prio_q;
    end
  end

  // duplicate check over the queued entries
  assign app_task = (op_q == OP_TICK) ? cur_q : tn_q;
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (CNT_W'(i) < cnt_q && ro_q[i] == app_task) begin
        dup = 1'b1;
      end
    end
  end
  assign app_ok = !dup && (cnt_q < CNT_W'(MAX_TASKS));

  assign ql_dec    = ql_q - QUANT_W'(1);
  assign preempt   = (cur_q != np_q);
  assign expire    = preempt && (ql_dec == '0);
  assign do_append = cmd_i.exec && app_ok &&
                     (op_q == OP_MAKE_READY || (op_q == OP_TICK && expire));

  // scan order: entries 1 .. count-1, then the head
  assign scan_j      = (k_q == cnt_q) ? '0 : k_q[TASK_W-1:0];
  assign scan_e      = ro_q[scan_j];
  assign scan_v      = dp_q[scan_e];
  assign scan_aged   = (scan_v <= PRIO_FLOOR) ? PRIO_FLOOR : scan_v - PRIO_ONE;
  assign scan_better = (scan_v <= bestp_q);
  assign pick_t      = ro_q[best_q];

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.op         = op_q;
  assign status_o.expire     = expire;
  assign status_o.count_zero = (cnt_q == '0);
  assign status_o.scan_last  = (k_q == cnt_q);
  assign status_o.out_free   = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(operation_i);
      tn_q   <= task_number_i;
      prio_q <= priority_req_i;
    end
    if (cmd_i.disp_init) begin
      best_q  <= '0;
      bestp_q <= PRIO_TOP;
    end else if (cmd_i.scan && scan_better) begin
      best_q  <= scan_j;
      bestp_q <= scan_v;
    end
    if (cmd_i.load) begin
      pt_q <= '0;
    end else if (cmd_i.pick) begin
      pt_q <= pick_t;
    end
    if (cmd_i.finish) begin
      chosen_valid_q <= pv_q;
      chosen_task_q  <= pt_q;
      queue_empty_q  <= (cnt_q == '0);
      system_time_q  <= tick_q;
    end
  end

  // ready queue entries, read only below the count
  always_ff @(posedge clk_i) begin
    if (do_append) begin
      ro_q[cnt_q[TASK_W-1:0]] <= app_task;
    end else if (cmd_i.pick) begin
      for (int i = 0; i < MAX_TASKS - 1; i++) begin
        if (TASK_W'(i) >= best_q) begin
          ro_q[i] <= ro_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        sp_q[i] <= '0;
        dp_q[i] <= '0;
      end
    end else if (cmd_i.exec && op_q == OP_SET_PRIO) begin
      sp_q[tn_q] <= prio_sat;
      dp_q[tn_q] <= prio_sat;
    end else if (cmd_i.scan) begin
      dp_q[scan_e] <= scan_aged;
    end else if (cmd_i.pick) begin
      dp_q[pick_t] <= sp_q[pick_t] - PRIO_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_q       <= '0;
      ql_q        <= QUANTUM_RST;
      tick_q      <= '0;
      qt_q        <= QUANTUM_RST;
      np_q        <= NONPRE_RST;
      k_q         <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_QUANTUM: qt_q <= cfg_data_i;
          CFG_NONPRE:  np_q <= cfg_data_i[TASK_W-1:0];
          default:     qt_q <= qt_q;
        endcase
      end
      if (cmd_i.exec && op_q == OP_TICK) begin
        tick_q <= tick_q + TIME_W'(1);
        if (preempt) begin
          ql_q <= expire ? qt_q : ql_dec;
        end
      end
      if (do_append) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.pick) begin
        cnt_q <= cnt_q - CNT_W'(1);
        cur_q <= pick_t;
      end
      if (cmd_i.disp_init) begin
        k_q <= CNT_W'(1);
      end else if (cmd_i.scan) begin
        k_q <= k_q + CNT_W'(1);
      end
      if (cmd_i.load) begin
        pv_q <= 1'b0;
      end else if (cmd_i.pick) begin
        pv_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_valid_o = chosen_valid_q;
  assign chosen_task_o  = chosen_task_q;
  assign queue_empty_o  = queue_empty_q;
  assign system_time_o  = system_time_q;

endmodule

// ===== rtl/priority_aging_task_scheduler.sv =====
// priority_aging_task_scheduler: top level, controller plus datapath
// sequence: set_priority, make_ready and non-expiring tick pass EXEC, then DONE raises the word;
// dispatch and expiring tick add DISP, then SCAN and PICK unless the queue is empty
// flow: one item at a time, stretched by output stalls
// reset: rst_ni asynchronous active low clears the task table, queue count and timers;
// queue entries are not reset, configuration returns to quantum 20 and exempt task 1

module priority_aging_task_scheduler import pats_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  pats_in_if.sink         in_i,
  pats_out_if.source      out_o,
  pats_cfg_if.sink        cfg_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_i.ready = 1'b1;

  pats_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pats_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (in_i.operation),
    .task_number_i  (in_i.task_number),
    .priority_req_i (in_i.priority_req),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .chosen_valid_o (out_o.chosen_valid),
    .chosen_task_o  (out_o.chosen_task),
    .queue_empty_o  (out_o.queue_empty),
    .system_time_o  (out_o.system_time)
  );

endmodule

// ===== rtl/pats_checker.sv =====
// pats_checker: port-level assertions of the scheduler, bound to the top level
// depends on pats_pkg for field widths

module pats_checker import pats_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              chosen_valid_i,
  input logic [TASK_W-1:0] chosen_task_i,
  input logic              queue_empty_i,
  input logic [TIME_W-1:0] system_time_i
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(chosen_valid_i) &&
      $stable(chosen_task_i) && $stable(queue_empty_i) && $stable(system_time_i))
    else $error("result word changed while stalled");

  // no task number without a dispatch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !chosen_valid_i |-> chosen_task_i == '0)
    else $error("chosen_task set without chosen_valid");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while busy");

  // a valid result word is fully known
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown({chosen_valid_i, chosen_task_i, queue_empty_i, system_time_i}))
    else $error("unknown bits in result word");

endmodule

bind priority_aging_task_scheduler pats_checker u_pats_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .chosen_valid_i (out_o.chosen_valid),
  .chosen_task_i  (out_o.chosen_task),
  .queue_empty_i  (out_o.queue_empty),
  .system_time_i  (out_o.system_time)
);
